// ===== sv/pi_rate_controller_feedforward_unit_defines.svh =====
// Assertion macros for the PI rate controller.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef PI_RATE_CONTROLLER_FEEDFORWARD_UNIT_DEFINES_SVH
`define PI_RATE_CONTROLLER_FEEDFORWARD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PRCF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PRCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/prcf_pkg.sv =====
// Shared widths, codes and reset values of the PI rate controller.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package prcf_pkg;

    localparam int DATA_W    = 32;
    localparam int INTEG_W   = 48;
    localparam int MAX_W     = 31;
    localparam int OP_W      = 2;
    localparam int CLIP_W    = 2;
    localparam int CFG_IDX_W = 8;

    // Serial unit lengths: one quotient bit or one gain bit per cycle
    localparam int DIV_STEPS = 48;
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = 6;

    // Operation codes
    localparam logic [OP_W-1:0] OP_POSITION = 2'd0;
    localparam logic [OP_W-1:0] OP_RATE     = 2'd1;
    localparam logic [OP_W-1:0] OP_TARGET   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET    = 2'd3;

    // Clip status codes
    localparam logic [CLIP_W-1:0] CLIP_NONE = 2'd0;
    localparam logic [CLIP_W-1:0] CLIP_HIGH = 2'd1;
    localparam logic [CLIP_W-1:0] CLIP_LOW  = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_P_GAIN        = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_I_GAIN        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SLOPE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT    = 8'd3;

    // Reset values (1.0 in Q16.16)
    localparam logic signed [DATA_W-1:0] SLOPE_RESET = 32'sd65536;
    localparam logic [MAX_W-1:0]         MAX_RESET   = 31'd65536;

    // Saturation limits
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [INTEG_W-1:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INTEG_W-1:0] S48_MIN = 48'sh8000_0000_0000;

endpackage

// ===== sv/prcf_if.sv =====
// Channel interfaces of the PI rate controller: sample in, result out, register write.
// Depends on prcf_pkg for widths.
`timescale 1ns / 1ps

// Input sample channel
interface prcf_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [prcf_pkg::OP_W-1:0]            operation;
    logic signed [prcf_pkg::DATA_W-1:0]   value;
    logic signed [prcf_pkg::DATA_W-1:0]   reset_rate;
    logic [prcf_pkg::DATA_W-1:0]          elapsed_time;

    modport source (output valid, operation, value, reset_rate, elapsed_time, input ready);
    modport sink   (input valid, operation, value, reset_rate, elapsed_time, output ready);
endinterface

// Result channel
interface prcf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [prcf_pkg::DATA_W-1:0]   control_output;
    logic [prcf_pkg::CLIP_W-1:0]          clip_state;

    modport source (output valid, control_output, clip_state, input ready);
    modport sink   (input valid, control_output, clip_state, output ready);
endinterface

// Register write channel
interface prcf_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [prcf_pkg::CFG_IDX_W-1:0]       index;
    logic [prcf_pkg::DATA_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/pi_rate_controller_feedforward_unit.sv =====
// PI rate controller with feed-forward and anti-windup, signed Q16.16 datapath.
// Depends on prcf_pkg, the interfaces in prcf_if.sv and the assertion macro header.
`timescale 1ns / 1ps
`include "pi_rate_controller_feedforward_unit_defines.svh"

// One sample beat in, one result beat out. Samples are handled one at a time;
// sample.ready is high only while the controller is free. A position sample
// with nonzero elapsed time first passes the restoring divider, which makes
// one quotient bit per cycle. Position and rate samples and target settings
// then pass two bit-serial shift-add multipliers that consume one gain bit
// per cycle (proportional and integral terms run side by side; a target uses
// only the first lane). A reset operation uses neither unit. A finished
// result sits in an output register while the next sample is taken.
// Register writes are always accepted; reset_rate has no effect on results.
module pi_rate_controller_feedforward_unit (
    input  logic            clk,
    input  logic            rst_n,
    prcf_in_if.sink         sample,
    prcf_out_if.source      result,
    prcf_cfg_if.sink        cfg
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_RATE,
        S_ERR,
        S_MUL,
        S_SUM,
        S_CLIP,
        S_TARGET,
        S_DONE
    } state_t;

    localparam int PROD_W = prcf_pkg::INTEG_W + 1 + 16;   // product >> 16
    localparam int SUM_W  = PROD_W + 2;

    state_t state_reg;

    // Registers and controller state
    logic signed [31:0] p_gain_reg, i_gain_reg, slope_reg;
    logic [30:0]        max_reg;
    logic signed [31:0] last_pos_reg, raw_target_reg, scaled_target_reg, drive_reg;
    logic signed [47:0] integ_reg, integ_prev_reg;

    // Per-sample working registers
    logic [1:0]         op_reg;
    logic [31:0]        dt_reg;
    logic               neg_reg;
    logic [47:0]        div_reg;
    logic [31:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic signed [31:0] rate_reg, err_reg;
    logic signed [SUM_W-1:0] sum_reg;

    // Two bit-serial multiplier lanes: 0 = proportional / slope, 1 = integral
    logic signed [47:0] mcand_reg [2];
    logic [31:0]        mplier_reg [2];
    logic signed [48:0] acc_reg [2];
    logic [31:0]        lo_reg [2];
    logic signed [48:0] acc_next [2];
    logic [31:0]        lo_next [2];
    logic signed [PROD_W-1:0] prod [2];

    // Pending and presented results
    logic signed [31:0] res_value_reg, out_value_reg;
    logic [1:0]         res_clip_reg, out_clip_reg;
    logic               out_valid_reg;

    assign sample.ready          = (state_reg == S_IDLE);
    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.control_output = out_value_reg;
    assign result.clip_state     = out_clip_reg;

    // Position difference and its magnitude (always fits 32 bits)
    logic signed [32:0] pos_diff, pos_diff_neg;
    logic [31:0]        diff_mag;
    assign pos_diff     = {sample.value[31], sample.value} - {last_pos_reg[31], last_pos_reg};
    assign pos_diff_neg = -pos_diff;
    assign diff_mag     = pos_diff[32] ? pos_diff_neg[31:0] : pos_diff[31:0];

    // Restoring divider step
    logic [32:0] rem_shift, rem_diff;
    logic        q_bit;
    logic [31:0] rem_new;
    assign rem_shift = {rem_reg, div_reg[47]};
    assign rem_diff  = rem_shift - {1'b0, dt_reg};
    assign q_bit     = (rem_shift >= {1'b0, dt_reg});
    assign rem_new   = q_bit ? rem_diff[31:0] : rem_shift[31:0];

    // Rate from quotient, saturated by sign
    logic [31:0]        q_neg;
    logic signed [31:0] div_rate;
    assign q_neg = -div_reg[31:0];
    always_comb
    begin
        if (neg_reg)
        begin
            div_rate = (div_reg > 48'h0000_8000_0000) ? prcf_pkg::S32_MIN : signed'(q_neg);
        end
        else
        begin
            div_rate = (div_reg > 48'h0000_7FFF_FFFF) ? prcf_pkg::S32_MAX
                                                       : signed'(div_reg[31:0]);
        end
    end

    // Error and integrator update, both saturating
    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic signed [48:0] integ_wide;
    logic signed [47:0] integ_sat;
    assign err_wide   = {scaled_target_reg[31], scaled_target_reg} - {rate_reg[31], rate_reg};
    assign err_sat    = (err_wide[32] != err_wide[31])
                        ? (err_wide[32] ? prcf_pkg::S32_MIN : prcf_pkg::S32_MAX)
                        : err_wide[31:0];
    assign integ_wide = 49'(integ_reg) + 49'(err_sat);
    assign integ_sat  = (integ_wide[48] != integ_wide[47])
                        ? (integ_wide[48] ? prcf_pkg::S48_MIN : prcf_pkg::S48_MAX)
                        : integ_wide[47:0];

    // Multiplier lane step: add the multiplicand on a set gain bit, subtract on
    // the sign bit, then shift the partial product right by one
    always_comb
    begin
        logic signed [49:0] addend;
        logic signed [49:0] acc_sum;
        for (int l = 0; l < 2; l++)
        begin
            addend  = mplier_reg[l][0] ? 50'(mcand_reg[l]) : 50'sd0;
            acc_sum = (cnt_reg == 6'(prcf_pkg::MUL_STEPS - 1))
                      ? 50'(acc_reg[l]) - addend
                      : 50'(acc_reg[l]) + addend;
            acc_next[l] = acc_sum[49:1];
            lo_next[l]  = {acc_sum[0], lo_reg[l][31:1]};
            prod[l]     = {acc_reg[l], lo_reg[l][31:16]};
        end
    end

    // Scaled target saturation
    logic               prod0_fits;
    logic signed [31:0] scaled_sat;
    assign prod0_fits = (&prod[0][PROD_W-1:31]) || !(|prod[0][PROD_W-1:31]);
    assign scaled_sat = prod0_fits ? prod[0][31:0]
                        : (prod[0][PROD_W-1] ? prcf_pkg::S32_MIN : prcf_pkg::S32_MAX);

    // Clip limits
    logic signed [SUM_W-1:0] max_pos, max_neg;
    logic                    over_high, over_low;
    assign max_pos   = signed'(SUM_W'(max_reg));
    assign max_neg   = -max_pos;
    assign over_high = (sum_reg > max_pos);
    assign over_low  = (sum_reg < max_neg);

    // Register writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_gain_reg <= '0;
            i_gain_reg <= '0;
            slope_reg  <= prcf_pkg::SLOPE_RESET;
            max_reg    <= prcf_pkg::MAX_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                prcf_pkg::REG_P_GAIN:        p_gain_reg <= signed'(cfg.data);
                prcf_pkg::REG_I_GAIN:        i_gain_reg <= signed'(cfg.data);
                prcf_pkg::REG_CONTROL_SLOPE: slope_reg  <= signed'(cfg.data);
                prcf_pkg::REG_MAX_OUTPUT:    max_reg    <= cfg.data[30:0];
                default: ;
            endcase
        end
    end

    // Sequencer, datapath registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            last_pos_reg      <= '0;
            raw_target_reg    <= '0;
            scaled_target_reg <= '0;
            integ_reg         <= '0;
            integ_prev_reg    <= '0;
            drive_reg         <= '0;
            op_reg            <= prcf_pkg::OP_POSITION;
            dt_reg            <= '0;
            neg_reg           <= 1'b0;
            div_reg           <= '0;
            rem_reg           <= '0;
            cnt_reg           <= '0;
            rate_reg          <= '0;
            err_reg           <= '0;
            sum_reg           <= '0;
            for (int l = 0; l < 2; l++)
            begin
                mcand_reg[l]  <= '0;
                mplier_reg[l] <= '0;
                acc_reg[l]    <= '0;
                lo_reg[l]     <= '0;
            end
            res_value_reg     <= '0;
            res_clip_reg      <= prcf_pkg::CLIP_NONE;
            out_value_reg     <= '0;
            out_clip_reg      <= prcf_pkg::CLIP_NONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            // S_DONE sets the valid itself
            if (result.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        op_reg  <= sample.operation;
                        dt_reg  <= sample.elapsed_time;
                        cnt_reg <= '0;
                        unique case (sample.operation)
                            prcf_pkg::OP_RESET:
                            begin
                                last_pos_reg  <= sample.value;
                                integ_reg     <= '0;
                                drive_reg     <= '0;
                                res_value_reg <= '0;
                                res_clip_reg  <= prcf_pkg::CLIP_NONE;
                                state_reg     <= S_DONE;
                            end
                            prcf_pkg::OP_TARGET:
                            begin
                                raw_target_reg <= sample.value;
                                mcand_reg[0]   <= 48'(sample.value);
                                mplier_reg[0]  <= slope_reg;
                                acc_reg[0]     <= '0;
                                lo_reg[0]      <= '0;
                                state_reg      <= S_MUL;
                            end
                            prcf_pkg::OP_POSITION:
                            begin
                                last_pos_reg <= sample.value;
                                neg_reg      <= pos_diff[32];
                                div_reg      <= {diff_mag, 16'h0000};
                                rem_reg      <= '0;
                                if (sample.elapsed_time == '0)
                                begin
                                    // zero time: full-scale rate by direction
                                    if (pos_diff == '0)
                                        rate_reg <= '0;
                                    else if (pos_diff[32])
                                        rate_reg <= prcf_pkg::S32_MIN;
                                    else
                                        rate_reg <= prcf_pkg::S32_MAX;
                                    state_reg <= S_ERR;
                                end
                                else
                                begin
                                    state_reg <= S_DIV;
                                end
                            end
                            prcf_pkg::OP_RATE:
                            begin
                                rate_reg  <= sample.value;
                                state_reg <= S_ERR;
                            end
                            default: ;
                        endcase
                    end
                end

                // One quotient bit per cycle
                S_DIV:
                begin
                    div_reg <= {div_reg[46:0], q_bit};
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(prcf_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= S_RATE;
                    end
                end

                S_RATE:
                begin
                    rate_reg  <= div_rate;
                    state_reg <= S_ERR;
                end

                // Error, integrator, and multiplier launch
                S_ERR:
                begin
                    err_reg        <= err_sat;
                    integ_prev_reg <= integ_reg;
                    integ_reg      <= integ_sat;
                    mcand_reg[0]   <= 48'(err_sat);
                    mplier_reg[0]  <= p_gain_reg;
                    mcand_reg[1]   <= integ_sat;
                    mplier_reg[1]  <= i_gain_reg;
                    for (int l = 0; l < 2; l++)
                    begin
                        acc_reg[l] <= '0;
                        lo_reg[l]  <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end

                // One gain bit per cycle in each lane
                S_MUL:
                begin
                    for (int l = 0; l < 2; l++)
                    begin
                        acc_reg[l]    <= acc_next[l];
                        lo_reg[l]     <= lo_next[l];
                        mplier_reg[l] <= {1'b0, mplier_reg[l][31:1]};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(prcf_pkg::MUL_STEPS - 1))
                    begin
                        state_reg <= (op_reg == prcf_pkg::OP_TARGET) ? S_TARGET : S_SUM;
                    end
                end

                // Feed-forward plus P and I terms, exact
                S_SUM:
                begin
                    sum_reg   <= SUM_W'(raw_target_reg) + SUM_W'(prod[0]) + SUM_W'(prod[1]);
                    state_reg <= S_CLIP;
                end

                // Clip and conditional anti-windup
                S_CLIP:
                begin
                    priority if (over_high)
                    begin
                        res_value_reg <= signed'({1'b0, max_reg});
                        drive_reg     <= signed'({1'b0, max_reg});
                        res_clip_reg  <= prcf_pkg::CLIP_HIGH;
                        if (err_reg > 0)
                            integ_reg <= integ_prev_reg;
                    end
                    else if (over_low)
                    begin
                        res_value_reg <= max_neg[31:0];
                        drive_reg     <= max_neg[31:0];
                        res_clip_reg  <= prcf_pkg::CLIP_LOW;
                        if (err_reg < 0)
                            integ_reg <= integ_prev_reg;
                    end
                    else
                    begin
                        res_value_reg <= sum_reg[31:0];
                        drive_reg     <= sum_reg[31:0];
                        res_clip_reg  <= prcf_pkg::CLIP_NONE;
                    end
                    state_reg <= S_DONE;
                end

                // New target: store scaled value, report held drive
                S_TARGET:
                begin
                    scaled_target_reg <= scaled_sat;
                    res_value_reg     <= drive_reg;
                    res_clip_reg      <= prcf_pkg::CLIP_NONE;
                    state_reg         <= S_DONE;
                end

                // Hand the result to the output register once it is free
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_value_reg <= res_value_reg;
                        out_clip_reg  <= res_clip_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Checks
    `PRCF_ASSERT_NEXT(a_busy_after_accept, sample.valid && sample.ready, !sample.ready,
        "sample accepted while busy")
    `PRCF_ASSERT(a_div_count, state_reg == S_DIV, cnt_reg < 6'(prcf_pkg::DIV_STEPS),
        "divider ran past its last step")
    `PRCF_ASSERT(a_clip_high_sign,
        result.valid && result.clip_state == prcf_pkg::CLIP_HIGH,
        !result.control_output[31], "high clip with negative output")
    `PRCF_ASSERT(a_clip_low_sign,
        result.valid && result.clip_state == prcf_pkg::CLIP_LOW,
        result.control_output[31] || result.control_output == '0,
        "low clip with positive output")
    `PRCF_ASSERT_NEXT(a_anti_windup, state_reg == S_CLIP && over_high && err_reg > 0,
        integ_reg == $past(integ_prev_reg), "integrator wound up while clipped high")

endmodule
